// ===== rtl/hsc_pkg.sv =====
// Shared types, constants and position-map functions for the Hamming SEC codec.
package hsc_pkg;

    localparam int DATA_W = 57;
    localparam int CW_W   = 63;
    localparam int POS_W  = 6;
    localparam int PAR_W  = 6;
    localparam int CNT_W  = 3;

    localparam logic [POS_W-1:0] MAX_DATA_BITS    = 6'd57;
    localparam logic [POS_W-1:0] RESET_DATA_BITS  = 6'd8;
    localparam logic             RESET_ODD_PARITY = 1'b1;

    // Configuration register indexes
    typedef logic [0:0] reg_index_t;
    localparam reg_index_t REG_DATA_BITS  = 1'b0;
    localparam reg_index_t REG_ODD_PARITY = 1'b1;

    // Transaction action codes
    localparam logic ACT_ENCODE = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    // Control carried from the front stage to the parity stage
    typedef struct packed {
        logic             action;
        logic             odd;
        logic [POS_W-1:0] n;
        logic [PAR_W-1:0] par_en;
    } front_ctrl_t;

    // Control carried from the parity stage to the correction stage
    typedef struct packed {
        logic             action;
        logic [POS_W-1:0] n;
        logic [PAR_W-1:0] syn;
    } check_ctrl_t;

    // Position (1-based) is a power of two: parity slot
    function automatic bit is_pow2(input int pos);
        return ((pos & (pos - 1)) == 0);
    endfunction

    // Data bit index held at a non-power-of-two position
    function automatic int data_index(input int pos);
        int lg;
        lg = 0;
        for (int s = 1; s < 8; s++) begin
            if ((pos >> s) != 0) lg = s;
        end
        return pos - 2 - lg;
    endfunction

    // Positions covered by parity group i, bit j-1 for position j
    function automatic logic [CW_W-1:0] group_mask(input int i);
        logic [CW_W-1:0] m;
        m = '0;
        for (int b = 0; b < CW_W; b++) begin
            m[b] = (((b + 1) >> i) & 1) != 0;
        end
        return m;
    endfunction

    // Smallest p with 2^p >= k+p+1; the test is monotone in p, so count hits
    function automatic logic [CNT_W-1:0] parity_count(input logic [POS_W-1:0] k);
        logic [CNT_W-1:0] p;
        p = 3'd1;
        for (int s = 1; s < PAR_W; s++) begin
            if ((7'd1 << s) < ({1'b0, k} + 7'(s) + 7'd1)) p = p + 3'd1;
        end
        return p;
    endfunction

endpackage

// ===== rtl/hsc_front.sv =====
// Stage 1: word geometry from configuration, input masking and data placement.
module hsc_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       action,
    input  logic [hsc_pkg::DATA_W-1:0] data_word,
    input  logic [hsc_pkg::CW_W-1:0]   received_word,
    input  logic [hsc_pkg::POS_W-1:0]  data_bits,
    input  logic                       odd_parity,
    output logic                       down_valid,
    input  logic                       down_stall,
    output logic [hsc_pkg::CW_W-1:0]   word,
    output hsc_pkg::front_ctrl_t       ctrl
);
    import hsc_pkg::*;

    logic [POS_W-1:0]  k_sat;
    logic [CNT_W-1:0]  p_cnt;
    logic [POS_W-1:0]  n_len;
    logic [DATA_W-1:0] k_mask;
    logic [CW_W-1:0]   n_mask;
    logic [PAR_W-1:0]  par_en;
    logic [DATA_W-1:0] data_masked;
    logic [CW_W-1:0]   placed;

    logic              valid_reg;
    logic [CW_W-1:0]   word_reg;
    logic [CW_W-1:0]   word_next;
    front_ctrl_t       ctrl_reg;
    front_ctrl_t       ctrl_next;

    // Clamp data length, derive parity count and codeword length
    always_comb
    begin
        if (data_bits == '0)
            k_sat = 6'd1;
        else if (data_bits > MAX_DATA_BITS)
            k_sat = MAX_DATA_BITS;
        else
            k_sat = data_bits;
        p_cnt = parity_count(k_sat);
        n_len = k_sat + {3'b000, p_cnt};
    end

    // Length masks
    for (genvar b = 0; b < DATA_W; b++) begin : g_kmask
        assign k_mask[b] = (6'(b) < k_sat);
    end
    for (genvar b = 0; b < CW_W; b++) begin : g_nmask
        assign n_mask[b] = (6'(b) < n_len);
    end
    for (genvar i = 0; i < PAR_W; i++) begin : g_paren
        assign par_en[i] = (3'(i) < p_cnt);
    end

    assign data_masked = data_word & k_mask;

    // Data bits go to non-power-of-two positions in order; parity slots zero
    for (genvar pos = 1; pos <= CW_W; pos++) begin : g_place
        if (is_pow2(pos)) begin : g_par
            assign placed[pos-1] = 1'b0;
        end
        else begin : g_dat
            assign placed[pos-1] = data_masked[data_index(pos)];
        end
    end

    always_comb
    begin
        word_next = (action == ACT_DECODE) ? (received_word & n_mask) : placed;
        ctrl_next.action = action;
        ctrl_next.odd    = odd_parity;
        ctrl_next.n      = n_len;
        ctrl_next.par_en = par_en;
    end

    // Stage hold when full and downstream stalls
    assign in_stall = valid_reg && down_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!in_stall)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            word_reg <= word_next;
            ctrl_reg <= ctrl_next;
        end
    end

    assign down_valid = valid_reg;
    assign word       = word_reg;
    assign ctrl       = ctrl_reg;

endmodule

// ===== rtl/hsc_parity.sv =====
// Stage 2: parity group XOR trees; parity insertion on encode, syndrome on decode.
module hsc_parity (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     up_valid,
    output logic                     up_stall,
    input  logic [hsc_pkg::CW_W-1:0] up_word,
    input  hsc_pkg::front_ctrl_t     up_ctrl,
    output logic                     down_valid,
    input  logic                     down_stall,
    output logic [hsc_pkg::CW_W-1:0] word,
    output hsc_pkg::check_ctrl_t     ctrl
);
    import hsc_pkg::*;

    logic [PAR_W-1:0] par_bits;
    logic [CW_W-1:0]  scatter;

    logic             valid_reg;
    logic [CW_W-1:0]  word_reg;
    logic [CW_W-1:0]  word_next;
    check_ctrl_t      ctrl_reg;
    check_ctrl_t      ctrl_next;

    // One XOR tree per group; groups past the parity count stay clear
    for (genvar i = 0; i < PAR_W; i++) begin : g_group
        localparam logic [CW_W-1:0] GMASK = group_mask(i);
        assign par_bits[i] = up_ctrl.par_en[i] & (up_ctrl.odd ^ (^(up_word & GMASK)));
    end

    // Parity bits to power-of-two positions
    always_comb
    begin
        scatter = '0;
        for (int i = 0; i < PAR_W; i++) begin
            scatter[(1 << i) - 1] = par_bits[i];
        end
    end

    always_comb
    begin
        ctrl_next.action = up_ctrl.action;
        ctrl_next.n      = up_ctrl.n;
        if (up_ctrl.action == ACT_DECODE)
        begin
            word_next     = up_word;
            ctrl_next.syn = par_bits;
        end
        else
        begin
            word_next     = up_word | scatter;
            ctrl_next.syn = '0;
        end
    end

    assign up_stall = valid_reg && down_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!up_stall)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
        begin
            word_reg <= word_next;
            ctrl_reg <= ctrl_next;
        end
    end

    assign down_valid = valid_reg;
    assign word       = word_reg;
    assign ctrl       = ctrl_reg;

endmodule

// ===== rtl/hsc_correct.sv =====
// Stage 3: single-bit correction, data extraction and the output register.
module hsc_correct (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        up_valid,
    output logic                        up_stall,
    input  logic [hsc_pkg::CW_W-1:0]    up_word,
    input  hsc_pkg::check_ctrl_t        up_ctrl,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [hsc_pkg::CW_W-1:0]    codeword,
    output logic [hsc_pkg::DATA_W-1:0]  data_out,
    output logic                        error_found,
    output logic [hsc_pkg::POS_W-1:0]   error_position,
    output logic                        position_invalid
);
    import hsc_pkg::*;

    logic              found;
    logic              invalid;
    logic [CW_W-1:0]   flip;
    logic [CW_W-1:0]   fixed;
    logic [DATA_W-1:0] extracted;

    logic              valid_reg;
    logic [CW_W-1:0]   codeword_reg;
    logic [CW_W-1:0]   codeword_next;
    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              found_reg;
    logic [POS_W-1:0]  position_reg;
    logic              invalid_reg;

    // Syndrome checks; out-of-range syndrome is flagged and not applied
    assign found   = (up_ctrl.action == ACT_DECODE) && (up_ctrl.syn != '0);
    assign invalid = found && (up_ctrl.syn > up_ctrl.n);

    for (genvar b = 0; b < CW_W; b++) begin : g_flip
        assign flip[b] = found && !invalid && (up_ctrl.syn == 6'(b + 1));
    end

    assign fixed = up_word ^ flip;

    // Pull data bits back out of non-power-of-two positions
    for (genvar pos = 1; pos <= CW_W; pos++) begin : g_extract
        if (!is_pow2(pos)) begin : g_dat
            assign extracted[data_index(pos)] = fixed[pos-1];
        end
    end

    always_comb
    begin
        codeword_next = fixed;
        data_next     = (up_ctrl.action == ACT_DECODE) ? extracted : '0;
    end

    assign up_stall = valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!up_stall)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
        begin
            codeword_reg <= codeword_next;
            data_reg     <= data_next;
            found_reg    <= found;
            position_reg <= up_ctrl.syn;
            invalid_reg  <= invalid;
        end
    end

    assign out_valid        = valid_reg;
    assign codeword         = codeword_reg;
    assign data_out         = data_reg;
    assign error_found      = found_reg;
    assign error_position   = position_reg;
    assign position_invalid = invalid_reg;

endmodule

// ===== rtl/hamming_sec_codec_core.sv =====
// Top level of the Hamming SEC codec: configuration registers and the three-stage pipeline.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one transaction per word: action selects
//   encode of data_word or check-and-correct of received_word.
//   Output channel (out_valid/out_stall) returns one result per transaction, in order:
//   codeword, data_out, error_found, error_position, position_invalid.
//   Configuration is a plain write port (cfg_write_en, cfg_index, cfg_data); index 0
//   sets the data length, index 1 selects odd parity. Write only while the pipe is empty.
// Pipeline and throughput:
//   Three register stages (geometry and placement, parity XOR trees, correction and
//   output register); a word passes through them in that order before out_valid rises.
//   While no stage is stalled a new word can be accepted every cycle; the rate is one
//   per cycle, set by the single pass through each stage.
// Reset:
//   rst_n clears all stage valid bits and restores data length 8 and odd parity.
// Stall:
//   A stalled output holds its result; each stage holds while full and blocked, and
//   in_stall rises only when the stalls reach the first stage. Empty stages keep
//   filling, so nothing is lost or repeated.
module hamming_sec_codec_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write_en,
    input  hsc_pkg::reg_index_t         cfg_index,
    input  logic [hsc_pkg::POS_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        action,
    input  logic [hsc_pkg::DATA_W-1:0]  data_word,
    input  logic [hsc_pkg::CW_W-1:0]    received_word,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [hsc_pkg::CW_W-1:0]    codeword,
    output logic [hsc_pkg::DATA_W-1:0]  data_out,
    output logic                        error_found,
    output logic [hsc_pkg::POS_W-1:0]   error_position,
    output logic                        position_invalid
);
    import hsc_pkg::*;

    logic [POS_W-1:0] data_bits_reg;
    logic [POS_W-1:0] data_bits_next;
    logic             odd_parity_reg;
    logic             odd_parity_next;

    logic             s1_valid;
    logic             s1_stall;
    logic [CW_W-1:0]  s1_word;
    front_ctrl_t      s1_ctrl;
    logic             s2_valid;
    logic             s2_stall;
    logic [CW_W-1:0]  s2_word;
    check_ctrl_t      s2_ctrl;

    // Configuration register writes
    always_comb
    begin
        data_bits_next  = data_bits_reg;
        odd_parity_next = odd_parity_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_DATA_BITS:  data_bits_next  = cfg_data;
                REG_ODD_PARITY: odd_parity_next = cfg_data[0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_bits_reg  <= RESET_DATA_BITS;
            odd_parity_reg <= RESET_ODD_PARITY;
        end
        else
        begin
            data_bits_reg  <= data_bits_next;
            odd_parity_reg <= odd_parity_next;
        end
    end

    // Stage 1: geometry and placement
    hsc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .data_word     (data_word),
        .received_word (received_word),
        .data_bits     (data_bits_reg),
        .odd_parity    (odd_parity_reg),
        .down_valid    (s1_valid),
        .down_stall    (s1_stall),
        .word          (s1_word),
        .ctrl          (s1_ctrl)
    );

    // Stage 2: parity groups
    hsc_parity u_parity (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (s1_valid),
        .up_stall   (s1_stall),
        .up_word    (s1_word),
        .up_ctrl    (s1_ctrl),
        .down_valid (s2_valid),
        .down_stall (s2_stall),
        .word       (s2_word),
        .ctrl       (s2_ctrl)
    );

    // Stage 3: correction and output
    hsc_correct u_correct (
        .clk              (clk),
        .rst_n            (rst_n),
        .up_valid         (s2_valid),
        .up_stall         (s2_stall),
        .up_word          (s2_word),
        .up_ctrl          (s2_ctrl),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .codeword         (codeword),
        .data_out         (data_out),
        .error_found      (error_found),
        .error_position   (error_position),
        .position_invalid (position_invalid)
    );

endmodule
